### hw/rtl/rts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rts_pkg: shared types and constants of the regex token segmenter
// Character codes, recognizer state encoding, beat and token list structs,
// and the class pattern lookup.
// ----------------------------------------------------------------------------
package rts_pkg;

    localparam int MAX_RES = 8;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_RBR  = 8'h5D;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7A;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UZ   = 8'h5A;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;

    // prefix length is the state code minus the base of its class
    localparam logic [3:0] DIGIT_BASE = 4'd1;
    localparam logic [3:0] ALPHA_BASE = 4'd4;
    localparam logic [2:0] DIGIT_LAST = 3'd4;
    localparam logic [2:0] ALPHA_LAST = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_ESC  = 4'd1,
        ST_D1   = 4'd2,
        ST_D2   = 4'd3,
        ST_D3   = 4'd4,
        ST_D4   = 4'd5,
        ST_A2   = 4'd6,
        ST_A3   = 4'd7,
        ST_A4   = 4'd8,
        ST_A5   = 4'd9,
        ST_A6   = 4'd10,
        ST_A7   = 4'd11
    } t_rec_state;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_expr;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tok_char;
        logic       token_end;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] tok_char;
        logic       token_end;
    } t_tok;

    typedef struct packed {
        t_tok [MAX_RES-1:0]  ent;
        logic [CNT_W-1:0]    cnt;
    } t_burst;

    // character idx of [0-9] (alpha = 0) or [a-zA-Z] (alpha = 1)
    function automatic logic [7:0] pat_char(input logic alpha, input logic [2:0] idx);
        logic [7:0] r;
        r = CH_LBR;
        if (alpha) begin
            case (idx)
                3'd0:    r = CH_LBR;
                3'd1:    r = CH_LA;
                3'd2:    r = CH_DASH;
                3'd3:    r = CH_LZ;
                3'd4:    r = CH_UA;
                3'd5:    r = CH_DASH;
                3'd6:    r = CH_UZ;
                default: r = CH_RBR;
            endcase
        end else begin
            case (idx)
                3'd0:    r = CH_LBR;
                3'd1:    r = CH_0;
                3'd2:    r = CH_DASH;
                3'd3:    r = CH_9;
                3'd4:    r = CH_RBR;
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/rts_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rts_decode: recognizer state and token list builder
// Turns one character into the list of token beats it releases and advances
// the recognizer state when the character is taken.
// ----------------------------------------------------------------------------
module rts_decode
    import rts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_take,
    input  wire t_in_item i_item,
    output t_burst        o_burst
);

    t_rec_state r_state;
    t_rec_state n_state;

    always_comb begin
        logic [7:0]  c;
        logic        blank;
        logic        alpha;
        logic        pref;
        logic [3:0]  st_bits;
        logic [2:0]  len;
        logic [2:0]  last_len;
        logic [7:0]  expect_c;
        t_rec_state  ns;
        logic [3:0]  ns_bits;
        logic        alpha2;
        logic [2:0]  len2;

        c        = i_item.ch;
        blank    = (c == CH_SP) || (c == CH_TAB);
        st_bits  = r_state;
        alpha    = r_state inside {[ST_A2:ST_A7]};
        pref     = r_state inside {[ST_D1:ST_A7]};
        len      = alpha ? 3'(st_bits - ALPHA_BASE) : 3'(st_bits - DIGIT_BASE);
        last_len = alpha ? ALPHA_LAST : DIGIT_LAST;
        expect_c = pat_char(alpha, len);
        o_burst  = '0;
        ns       = ST_IDLE;

        if (pref) begin
            if (c == expect_c) begin
                if (len == last_len) begin
                    // class complete: release the whole pattern as one token
                    for (int i = 0; i < MAX_RES; i++) begin
                        if (3'(i) <= last_len) begin
                            o_burst.ent[i] = '{tok_char: pat_char(alpha, 3'(i)),
                                               token_end: (3'(i) == last_len)};
                        end
                    end
                    o_burst.cnt = CNT_W'(last_len) + CNT_W'(1);
                end else begin
                    ns = t_rec_state'(st_bits + 4'd1);
                end
            end else if (r_state == ST_D1 && c == CH_LA) begin
                ns = ST_A2;
            end else begin
                // broken prefix: flush as single tokens, drop a blank breaker
                for (int i = 0; i < MAX_RES; i++) begin
                    if (3'(i) < len) begin
                        o_burst.ent[i] = '{tok_char: pat_char(alpha, 3'(i)), token_end: 1'b1};
                    end else if (3'(i) == len) begin
                        o_burst.ent[i] = '{tok_char: c, token_end: 1'b1};
                    end
                end
                o_burst.cnt = CNT_W'(len) + CNT_W'(!blank);
            end
        end else if (r_state == ST_ESC) begin
            o_burst.ent[0] = '{tok_char: CH_BSL, token_end: 1'b0};
            o_burst.ent[1] = '{tok_char: c, token_end: 1'b1};
            o_burst.cnt    = CNT_W'(2);
        end else begin
            if (c == CH_BSL) begin
                ns = ST_ESC;
            end else if (c == CH_LBR) begin
                ns = ST_D1;
            end else if (!blank) begin
                o_burst.ent[0] = '{tok_char: c, token_end: 1'b1};
                o_burst.cnt    = CNT_W'(1);
            end
        end

        // end of expression: pending text leaves as one token
        ns_bits = ns;
        alpha2  = ns inside {[ST_A2:ST_A7]};
        len2    = alpha2 ? 3'(ns_bits - ALPHA_BASE) : 3'(ns_bits - DIGIT_BASE);
        if (i_item.end_of_expr && ns != ST_IDLE) begin
            if (ns == ST_ESC) begin
                o_burst.ent[0] = '{tok_char: CH_BSL, token_end: 1'b1};
                o_burst.cnt    = CNT_W'(1);
            end else begin
                for (int i = 0; i < MAX_RES; i++) begin
                    if (3'(i) < len2) begin
                        o_burst.ent[i] = '{tok_char: pat_char(alpha2, 3'(i)),
                                           token_end: (3'(i) + 3'd1 == len2)};
                    end
                end
                o_burst.cnt = CNT_W'(len2);
            end
            ns = ST_IDLE;
        end

        n_state = ns;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else if (i_take) begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/rts_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rts_serializer: token list buffer and output register
// Holds the beats released by one character and hands them to the output
// register one per cycle when not stalled, flagging the list's final beat.
// ----------------------------------------------------------------------------
module rts_serializer
    import rts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_burst    i_burst,
    output logic           o_burst_free,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    t_burst           r_burst;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic out_free;
    logic advance;
    logic at_last;
    t_tok cur;

    assign out_free     = !r_out_valid || i_out_ready;
    assign advance      = r_busy && out_free;
    assign at_last      = (CNT_W'(r_idx) + CNT_W'(1)) == r_burst.cnt;
    assign cur          = r_burst.ent[r_idx];
    assign o_burst_free = !r_busy || (advance && at_last);
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_busy;
            end
            // a new list only loads once the old one is on its final beat
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (advance) begin
                r_idx <= at_last ? '0 : r_idx + IDX_W'(1);
                if (at_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= '{tok_char: cur.tok_char, token_end: cur.token_end, last: at_last};
        end
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/regex_token_segmenter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// regex_token_segmenter_unit: rule expression token segmenter
// Splits a character stream into escape, class and single-character tokens.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the list buffer is free. A character
// that releases k token beats holds the output until all have left (k is at
// most 8, usually 0 or 1), since the beats leave one per cycle, unless the
// output stalls, through the single output register; the input register
// keeps taking the next character meanwhile and stalls only once it is full.
// Output beats pass the input register, list buffer and output register.
module regex_token_segmenter_unit
    import rts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic     r_in_valid;
    t_in_item r_in;
    logic     take;
    logic     burst_free;
    t_burst   burst;

    assign take       = r_in_valid && burst_free;
    assign o_in_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    rts_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (r_in),
        .o_burst (burst)
    );

    rts_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (take && (burst.cnt != '0)),
        .i_burst      (burst),
        .o_burst_free (burst_free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
`default_nettype wire

### hw/rtl/rts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rts_checker: port level checks of the token segmenter
// Watches the output channel for stall behavior and token framing.
// ----------------------------------------------------------------------------
module rts_checker
    import rts_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // an accepted input beat carries known data
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> !$isunknown(i_in_data))
        else $error("unknown input beat accepted");

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // the final beat of a character always closes a token
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.token_end |-> !o_out_data.last)
        else $error("last beat inside an open token");

    // an open token continues with no bubble
    a_tok_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.token_end |=> o_out_valid)
        else $error("gap inside a token");

endmodule

bind regex_token_segmenter_unit rts_checker u_rts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

### bench/regex_token_segmenter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regex_token_segmenter_checker: scoreboard of the token segmenter
// Watches both channels. Every accepted character is run through a local
// recognizer that queues the token beats it releases. Every accepted output
// beat is compared field by field with the oldest queued beat.
// ----------------------------------------------------------------------------
module regex_token_segmenter_checker
    import rts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_item i_out_data,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_beats_checked
);

    // class texts, first character in the low byte
    localparam logic [39:0] DIGIT_TEXT = {CH_RBR, CH_9, CH_DASH, CH_0, CH_LBR};
    localparam logic [63:0] ALPHA_TEXT = {CH_RBR, CH_UZ, CH_DASH, CH_UA,
                                          CH_LZ, CH_DASH, CH_LA, CH_LBR};
    localparam int MAX_REPORTS = 20;

    logic [3:0] seg_state = ST_IDLE;
    t_out_item  tok_burst[$];
    t_out_item  tok_expect_q[$];
    t_out_item  want;
    int         fail_count = 0;
    int         beats_checked = 0;

    function automatic logic [7:0] class_char(input logic alpha, input int idx);
        return alpha ? ALPHA_TEXT[idx*8 +: 8] : DIGIT_TEXT[idx*8 +: 8];
    endfunction

    function automatic void add_tok(input logic [7:0] c, input logic end_flag);
        t_out_item t;
        t.tok_char  = c;
        t.token_end = end_flag;
        t.last      = 1'b0;
        tok_burst.insert(tok_burst.size(), t);
    endfunction

    // whole: one token ending on the last char; else one token per char
    function automatic void emit_prefix(input logic alpha, input int len, input logic whole);
        int i;
        for (i = 0; i < len; i++)
            add_tok(class_char(alpha, i), whole ? (i == len - 1) : 1'b1);
    endfunction

    function automatic void segment_beat(input t_in_item it);
        logic [3:0] s;
        int         len;
        int         plen;
        logic       alpha;
        logic       blank;
        t_out_item  t;
        s = seg_state;
        if (s > ST_A7)
            s = ST_IDLE;
        blank = (it.ch == CH_SP) || (it.ch == CH_TAB);
        alpha = (s >= ST_A2);
        len   = alpha ? int'(s - ALPHA_BASE) : int'(s - DIGIT_BASE);
        plen  = alpha ? 8 : 5;
        tok_burst.delete();
        if (s == ST_IDLE) begin
            if (it.ch == CH_BSL)
                s = ST_ESC;
            else if (it.ch == CH_LBR)
                s = ST_D1;
            else if (!blank)
                add_tok(it.ch, 1'b1);
        end else if (s == ST_ESC) begin
            add_tok(CH_BSL, 1'b0);
            add_tok(it.ch, 1'b1);
            s = ST_IDLE;
        end else if (it.ch == class_char(alpha, len)) begin
            if (len + 1 == plen) begin
                emit_prefix(alpha, plen, 1'b1);
                s = ST_IDLE;
            end else begin
                // codes of one class are consecutive
                s = s + 4'd1;
            end
        end else if (s == ST_D1 && it.ch == CH_LA) begin
            s = ST_A2;
        end else begin
            emit_prefix(alpha, len, 1'b0);
            if (!blank)
                add_tok(it.ch, 1'b1);
            s = ST_IDLE;
        end

        // flush whatever is still pending at the end of the expression
        if (it.end_of_expr && s != ST_IDLE) begin
            if (s == ST_ESC) begin
                add_tok(CH_BSL, 1'b1);
            end else begin
                alpha = (s >= ST_A2);
                len   = alpha ? int'(s - ALPHA_BASE) : int'(s - DIGIT_BASE);
                emit_prefix(alpha, len, 1'b1);
            end
            s = ST_IDLE;
        end
        seg_state = s;

        if (tok_burst.size() > 0) begin
            t = tok_burst[tok_burst.size() - 1];
            t.last = 1'b1;
            tok_burst[tok_burst.size() - 1] = t;
        end
        foreach (tok_burst[i])
            tok_expect_q.insert(tok_expect_q.size(), tok_burst[i]);
    endfunction

    function automatic void report(input string field, input int exp_v, input int got_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, exp_v, got_v);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_state = ST_IDLE;
            tok_expect_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                segment_beat(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (tok_expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected beat, expected none, got char 0x%0h end %0b last %0b",
                                 $time, i_out_data.tok_char, i_out_data.token_end,
                                 i_out_data.last);
                end else begin
                    want = tok_expect_q.pop_front();
                    beats_checked++;
                    if (want.tok_char !== i_out_data.tok_char)
                        report("tok_char", want.tok_char, i_out_data.tok_char);
                    if (want.token_end !== i_out_data.token_end)
                        report("token_end", want.token_end, i_out_data.token_end);
                    if (want.last !== i_out_data.last)
                        report("last", want.last, i_out_data.last);
                end
            end
        end
        o_fail_count    <= fail_count;
        o_pending       <= tok_expect_q.size();
        o_beats_checked <= beats_checked;
    end

endmodule

### bench/tb_regex_token_segmenter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_regex_token_segmenter_unit: regression of the token segmenter
// Sends directed expressions (complete classes, escapes, broken prefixes,
// end-of-expression flushes) and then random expression fragments with
// random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_regex_token_segmenter_unit;
    import rts_pkg::*;

    localparam int N_ITEMS     = 410;
    localparam int PHASE_ITEMS = 77;
    localparam int HOLD_CYCLES = 250;
    localparam int STALL_LIMIT = 3000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int chk_fail;
    int chk_pending;
    int chk_beats;

    logic [7:0] frag[$];
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    int  rx_hold_len = 0;
    int  n_sent = 0;
    int  n_eoe = 0;
    int  idle_cycles = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    regex_token_segmenter_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    regex_token_segmenter_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_data),
        .o_fail_count    (chk_fail),
        .o_pending       (chk_pending),
        .o_beats_checked (chk_beats)
    );

    // end the run if no beat moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("regex_token_segmenter_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall before each beat, plus the long hold on request
    initial begin : rx_side
        int wait_cycles;
        while (!rst_n)
            @(posedge clk);
        forever begin
            wait_cycles = rx_hold_len + (rx_calm ? 0 : $urandom_range(0, 15));
            rx_hold_len = 0;
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic eoe);
        int       gap;
        t_in_item item;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.ch          = c;
        item.end_of_expr = eoe;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
        if (eoe)
            n_eoe++;
    endtask

    function automatic void add_char(input logic [7:0] c);
        frag.insert(frag.size(), c);
    endfunction

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    // noisy: sprinkle stray end-of-expression marks inside the fragment
    task automatic send_frag(input logic eoe_last, input bit noisy);
        int   i;
        logic eoe;
        for (i = 0; i < frag.size(); i++) begin
            eoe = noisy && ($urandom_range(0, 31) == 0);
            if (i == frag.size() - 1)
                eoe = eoe | eoe_last;
            send_beat(frag[i], eoe);
        end
        frag.delete();
    endtask

    task automatic build_random_frag(input bit dense, output logic eoe_last);
        int         kind;
        int         cut;
        string      pat;
        logic [7:0] rb;
        pat = ($urandom_range(0, 1) == 1) ? "[a-zA-Z]" : "[0-9]";
        kind = dense ? $urandom_range(0, 2) : $urandom_range(0, 9);
        rb = $urandom_range(0, 255);
        eoe_last = ($urandom_range(0, 3) == 0);
        case (kind)
            0, 1, 2: add_text(pat);
            3, 4: begin
                cut = $urandom_range(1, pat.len() - 1);
                add_text(pat.substr(0, cut - 1));
                case ($urandom_range(0, 5))
                    0: add_char(rb);
                    1: add_char(rb[0] ? CH_SP : CH_TAB);
                    2: add_char(CH_BSL);
                    3: add_char(CH_LBR);
                    4: add_char(CH_LA);
                    default: eoe_last = 1'b1;  // flush the bare prefix
                endcase
            end
            5: begin
                add_char(CH_BSL);
                add_char(rb);
            end
            6: add_char(rb[0] ? CH_SP : CH_TAB);
            default: add_char(rb);
        endcase
    endtask

    // hold the input until every queued beat has come out
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (chk_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    initial begin : stimulus
        int   phase;
        int   phase_end;
        logic eoe_last;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_char(8'h00);
        send_frag(1'b0, 1'b0);
        add_char(8'hFF);
        send_frag(1'b1, 1'b0);
        add_text("[0-9]");
        send_frag(1'b0, 1'b0);
        add_text("[a-zA-Z]");
        send_frag(1'b0, 1'b0);
        add_char(CH_BSL);
        add_char(CH_SP);
        send_frag(1'b0, 1'b0);
        add_text("[0-");
        add_char(CH_TAB);
        send_frag(1'b0, 1'b0);
        add_text("[a");
        send_frag(1'b1, 1'b0);
        add_char(CH_BSL);
        send_frag(1'b1, 1'b0);
        add_char(CH_SP);
        send_frag(1'b0, 1'b0);
        add_text("[[");
        send_frag(1'b1, 1'b0);
        drain();

        for (phase = 0; n_sent < N_ITEMS; phase++) begin
            tx_calm = (phase % 4 == 1) || (phase % 4 == 2);
            rx_calm = (phase % 4 == 1) || (phase % 4 == 3);
            // fill the block while the receiver holds off
            if (phase == 1)
                rx_hold_len = HOLD_CYCLES;
            phase_end = n_sent + PHASE_ITEMS;
            while (n_sent < phase_end && n_sent < N_ITEMS) begin
                build_random_frag(phase == 1, eoe_last);
                send_frag(eoe_last, 1'b1);
            end
            drain();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (8) @(posedge clk);

        $display("Covered %0d characters (%0d closing an expression) over %0d phases,",
                 n_sent, n_eoe, phase);
        $display("with %0d token beats compared against the prediction.", chk_beats);
        if (chk_fail == 0 && chk_pending == 0)
            $display("regex_token_segmenter_unit regression: pass");
        else
            $display("regex_token_segmenter_unit regression: fail");
        $finish;
    end

endmodule
